// ===== rtl/rvx_pkg.sv =====
// Shared types and constants for the RV32I executor.
// No dependencies; used by rvx_front, rvx_back and the top level in rtl/.
package rvx_pkg;

    // Byte memory size; must be a power of two (addresses wrap by masking).
    localparam int MEM_BYTES = 262144;
    localparam int MEM_ROWS  = MEM_BYTES / 4;
    localparam int BYTE_W    = $clog2(MEM_BYTES);
    localparam int ROW_W     = $clog2(MEM_ROWS);

    localparam logic KIND_STEP    = 1'b0;
    localparam logic KIND_PRELOAD = 1'b1;

    localparam logic [6:0]  OP_MASK    = 7'h7F;
    localparam logic [6:0]  OP_LUI     = 7'h37;
    localparam logic [6:0]  OP_AUIPC   = 7'h17;
    localparam logic [6:0]  OP_JAL     = 7'h6F;
    localparam logic [6:0]  OP_JALR    = 7'h67;
    localparam logic [6:0]  OP_BRANCH  = 7'h63;
    localparam logic [6:0]  OP_LOAD    = 7'h03;
    localparam logic [6:0]  OP_STORE   = 7'h23;
    localparam logic [6:0]  OP_IMM     = 7'h13;
    localparam logic [6:0]  OP_REG     = 7'h33;
    localparam logic [6:0]  OP_SYSTEM  = 7'h73;
    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
    localparam logic [31:0] JALR_MASK  = 32'hFFFF_FFFE;
    localparam logic [6:0]  F7_ADD     = 7'h00;
    localparam logic [6:0]  F7_SUB     = 7'h20;

    typedef enum logic [2:0] {
        ST_EXEC    = 3'd0,
        ST_ILLEGAL = 3'd1,
        ST_HALT    = 3'd2,
        ST_PRELOAD = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    typedef struct packed {
        logic [31:0] load_data;
        logic [15:0] word_address;
        logic        kind;
    } item_t;

    // Last field (status) in the lowest bits.
    typedef struct packed {
        logic [31:0] exit_code;
        logic [31:0] next_pc;
        logic [31:0] fetched_instruction;
        logic [31:0] executed_pc;
        status_t     status;
    } result_t;

    localparam int RES_W   = $bits(result_t);
    localparam int MDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

// ===== rtl/rvx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rvx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/rvx_front.sv =====
// Front end: accepts input items, unpacks them and holds them in a 2-entry queue.
// Depends on rvx_pkg.
module rvx_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [47:0]    s_tdata,   // word_address[15:0], load_data[47:16]
    input  logic           s_tuser,   // kind
    output logic           q_valid,
    output rvx_pkg::item_t q_item,
    input  logic           q_pop
);
    rvx_pkg::item_t ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    rvx_pkg::item_t in_item;

    always_comb begin
        in_item.kind         = s_tuser;
        in_item.word_address = s_tdata[15:0];
        in_item.load_data    = s_tdata[47:16];
    end

    // held low through reset so no item is taken while the queue is cleared
    assign s_tready = aresetn && (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= in_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop && q_valid) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end
endmodule

// ===== rtl/rvx_back.sv =====
// Back end: sequencer that executes one queued item at a time against the
// byte memory (four byte banks) and the register file. Depends on rvx_pkg, rvx_ram.
module rvx_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  rvx_pkg::item_t  q_item,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output rvx_pkg::result_t m_res
);
    localparam int RW = rvx_pkg::ROW_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_EXEC, S_LOAD, S_DONE
    } state_t;

    state_t state_reg;
    logic [RW-1:0] clr_reg;
    logic [31:0] pc_reg, ins_reg, x3_reg;
    logic [1:0]  lo_reg;
    logic        halted_reg;
    logic [31:0] rfv_reg;
    rvx_pkg::result_t res_reg, out_reg;
    logic        out_valid_reg;

    // byte banks
    logic          bk_we    [4];
    logic [RW-1:0] bk_waddr [4];
    logic [7:0]    bk_wdata [4];
    logic [RW-1:0] bk_raddr [4];
    logic [7:0]    bk_rdata [4];

    // register file, duplicated for two read ports
    logic        rf_we;
    logic [4:0]  rf_waddr, rf_ra1, rf_ra2;
    logic [31:0] rf_wdata, rf_rd1, rf_rd2;

    logic [31:0] rbase, wbase, asm_word, a, b;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, ex_next, ex_val, ls_addr;
    logic        ex_ok, ex_wr, ex_load, ex_store, ex_halt;
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] ld_val;
    logic        out_free;

    for (genvar g = 0; g < 4; g++) begin : g_bank
        rvx_ram #(.WIDTH(8), .DEPTH(rvx_pkg::MEM_ROWS)) u_bank (
            .aclk (aclk), .we(bk_we[g]), .waddr(bk_waddr[g]), .wdata(bk_wdata[g]),
            .raddr(bk_raddr[g]), .rdata(bk_rdata[g])
        );
    end

    rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf1 (
        .aclk(aclk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rf_ra1), .rdata(rf_rd1)
    );
    rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf2 (
        .aclk(aclk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rf_ra2), .rdata(rf_rd2)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;

    // assemble four bytes starting at the bank lo_reg points to
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            asm_word[8*i +: 8] = bk_rdata[2'(lo_reg + 2'(i))];
        end
    end

    assign op = ins_reg[6:0] & rvx_pkg::OP_MASK;
    assign rd = ins_reg[11:7];
    assign f3 = ins_reg[14:12];
    assign f7 = ins_reg[31:25];
    assign a  = rfv_reg[ins_reg[19:15]] ? rf_rd1 : 32'd0;
    assign b  = rfv_reg[ins_reg[24:20]] ? rf_rd2 : 32'd0;
    assign imm_i = {{20{ins_reg[31]}}, ins_reg[31:20]};
    assign imm_s = {{20{ins_reg[31]}}, ins_reg[31:25], ins_reg[11:7]};
    assign imm_b = {{19{ins_reg[31]}}, ins_reg[31], ins_reg[7], ins_reg[30:25],
                    ins_reg[11:8], 1'b0};
    assign imm_j = {{11{ins_reg[31]}}, ins_reg[31], ins_reg[19:12], ins_reg[20],
                    ins_reg[30:21], 1'b0};

    // execute
    always_comb begin
        ex_next  = pc_reg + 32'd4;
        ex_ok    = 1'b1;
        ex_wr    = 1'b0;
        ex_val   = 32'd0;
        ex_load  = 1'b0;
        ex_store = 1'b0;
        ex_halt  = 1'b0;
        ls_addr  = a + imm_i;
        case (op)
            rvx_pkg::OP_LUI: begin
                ex_wr = 1'b1; ex_val = {ins_reg[31:12], 12'd0};
            end
            rvx_pkg::OP_AUIPC: begin
                ex_wr = 1'b1; ex_val = pc_reg + {ins_reg[31:12], 12'd0};
            end
            rvx_pkg::OP_JAL: begin
                ex_wr = 1'b1; ex_val = pc_reg + 32'd4; ex_next = pc_reg + imm_j;
            end
            rvx_pkg::OP_JALR: begin
                ex_wr = 1'b1; ex_val = pc_reg + 32'd4;
                ex_next = (a + imm_i) & rvx_pkg::JALR_MASK;
            end
            rvx_pkg::OP_BRANCH: begin
                case (f3)
                    3'd0: if (a == b) ex_next = pc_reg + imm_b;
                    3'd1: if (a != b) ex_next = pc_reg + imm_b;
                    3'd4: if ($signed(a) < $signed(b)) ex_next = pc_reg + imm_b;
                    3'd5: if (!($signed(a) < $signed(b))) ex_next = pc_reg + imm_b;
                    3'd6: if (a < b) ex_next = pc_reg + imm_b;
                    3'd7: if (a >= b) ex_next = pc_reg + imm_b;
                    default: ex_ok = 1'b0;
                endcase
            end
            rvx_pkg::OP_LOAD: begin
                ex_load = 1'b1;
                if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) ex_ok = 1'b0;
            end
            rvx_pkg::OP_STORE: begin
                ls_addr  = a + imm_s;
                ex_store = 1'b1;
                if (f3 > 3'd2) ex_ok = 1'b0;
            end
            rvx_pkg::OP_IMM: begin
                ex_wr = 1'b1;
                case (f3)
                    3'd0: ex_val = a + imm_i;
                    3'd1: ex_val = a << imm_i[4:0];
                    3'd2: ex_val = {31'd0, $signed(a) < $signed(imm_i)};
                    3'd3: ex_val = {31'd0, a < imm_i};
                    3'd4: ex_val = a ^ imm_i;
                    3'd5: ex_val = ins_reg[30] ? 32'($signed(a) >>> imm_i[4:0])
                                               : a >> imm_i[4:0];
                    3'd6: ex_val = a | imm_i;
                    default: ex_val = a & imm_i;
                endcase
            end
            rvx_pkg::OP_REG: begin
                ex_wr = 1'b1;
                case (f3)
                    3'd0: begin
                        if (f7 == rvx_pkg::F7_ADD) ex_val = a + b;
                        else if (f7 == rvx_pkg::F7_SUB) ex_val = a - b;
                        else ex_ok = 1'b0;
                    end
                    3'd1: ex_val = a << b[4:0];
                    3'd2: ex_val = {31'd0, $signed(a) < $signed(b)};
                    3'd3: ex_val = {31'd0, a < b};
                    3'd4: ex_val = a ^ b;
                    3'd5: ex_val = (f7 != 7'd0) ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
                    3'd6: ex_val = a | b;
                    default: ex_val = a & b;
                endcase
            end
            rvx_pkg::OP_SYSTEM: begin
                if (ins_reg == rvx_pkg::ECALL_WORD) begin
                    ex_halt = 1'b1; ex_next = pc_reg;
                end else begin
                    ex_ok = 1'b0;
                end
            end
            default: ex_ok = 1'b0;
        endcase
        if (!ex_ok) begin
            ex_next = pc_reg + 32'd4;
        end
    end

    // load data extraction
    always_comb begin
        case (f3)
            3'd0:    ld_val = {{24{asm_word[7]}}, asm_word[7:0]};
            3'd1:    ld_val = {{16{asm_word[15]}}, asm_word[15:0]};
            3'd4:    ld_val = {24'd0, asm_word[7:0]};
            3'd5:    ld_val = {16'd0, asm_word[15:0]};
            default: ld_val = asm_word;
        endcase
    end

    // bank ports: reads at pc on fetch, at ls_addr in execute
    assign rbase = (state_reg == S_EXEC) ? ls_addr : pc_reg;
    assign wbase = ls_addr;
    always_comb begin
        logic [1:0] idx;
        for (int g = 0; g < 4; g++) begin
            bk_raddr[g] = rbase[rvx_pkg::BYTE_W-1:2] + RW'(2'(g) < rbase[1:0]);
            bk_we[g]    = 1'b0;
            bk_waddr[g] = wbase[rvx_pkg::BYTE_W-1:2] + RW'(2'(g) < wbase[1:0]);
            idx         = 2'(2'(g) - wbase[1:0]);
            bk_wdata[g] = b[8*idx +: 8];
            case (state_reg)
                S_CLEAR: begin
                    bk_we[g] = 1'b1; bk_waddr[g] = clr_reg; bk_wdata[g] = 8'd0;
                end
                S_IDLE: begin
                    bk_we[g]    = q_valid && (q_item.kind == rvx_pkg::KIND_PRELOAD);
                    bk_waddr[g] = RW'(q_item.word_address);
                    bk_wdata[g] = q_item.load_data[8*g +: 8];
                end
                S_EXEC: begin
                    bk_we[g] = ex_store && ex_ok &&
                               ((f3 == 3'd2) || (f3 == 3'd1 && idx < 2'd2) ||
                                (f3 == 3'd0 && idx == 2'd0));
                end
                default: bk_we[g] = 1'b0;
            endcase
        end
    end

    // register file ports
    assign rf_ra1 = asm_word[19:15];
    assign rf_ra2 = asm_word[24:20];
    assign rf_waddr = rd;
    always_comb begin
        rf_we    = 1'b0;
        rf_wdata = ex_val;
        if (state_reg == S_EXEC) begin
            rf_we = ex_wr && ex_ok && (rd != 5'd0);
        end else if (state_reg == S_LOAD) begin
            rf_we    = (rd != 5'd0);
            rf_wdata = ld_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pc_reg        <= 32'd0;
            halted_reg    <= 1'b0;
            rfv_reg       <= 32'd0;
            x3_reg        <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (rf_we) begin
                rfv_reg[rf_waddr] <= 1'b1;
                if (rf_waddr == 5'd3) x3_reg <= rf_wdata;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + RW'(1);
                    if (clr_reg == RW'(rvx_pkg::MEM_ROWS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (q_valid) begin
                        res_reg.executed_pc         <= 32'd0;
                        res_reg.fetched_instruction <= 32'd0;
                        res_reg.next_pc             <= pc_reg;
                        res_reg.exit_code           <= 32'd0;
                        if (q_item.kind == rvx_pkg::KIND_PRELOAD) begin
                            res_reg.status <= rvx_pkg::ST_PRELOAD;
                            state_reg      <= S_DONE;
                        end else if (halted_reg) begin
                            res_reg.status      <= rvx_pkg::ST_IGNORED;
                            res_reg.executed_pc <= pc_reg;
                            state_reg           <= S_DONE;
                        end else begin
                            lo_reg    <= pc_reg[1:0];
                            state_reg <= S_DECODE;
                        end
                    end
                end
                S_DECODE: begin
                    ins_reg   <= asm_word;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    res_reg.executed_pc         <= pc_reg;
                    res_reg.fetched_instruction <= ins_reg;
                    res_reg.next_pc             <= ex_next;
                    res_reg.exit_code           <= ex_halt ? x3_reg : 32'd0;
                    res_reg.status <= !ex_ok ? rvx_pkg::ST_ILLEGAL :
                                      ex_halt ? rvx_pkg::ST_HALT : rvx_pkg::ST_EXEC;
                    pc_reg   <= ex_next;
                    lo_reg   <= ls_addr[1:0];
                    if (ex_halt) halted_reg <= 1'b1;
                    state_reg <= (ex_load && ex_ok) ? S_LOAD : S_DONE;
                end
                S_LOAD: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/rv32i_instruction_executor_core.sv =====
// RV32I executor top level: front queue, execution back end, stream ports.
// Depends on rvx_pkg, rvx_front, rvx_back (and rvx_ram below it).
//
// After reset the block zeroes its byte memory, one 4-byte row per cycle,
// MEM_BYTES/4 rows (65536 by default); meanwhile up to two items are
// queued but none is executed. Items enter through a 2-entry queue. A step
// item passes through the synchronous fetch read, register-file read, execute
// and, for a load only, the load read; a preload or an ignored step goes
// from idle straight to done. Results wait in an output register, so the next
// item is started while a result is still waiting to be taken.
module rv32i_instruction_executor_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,  // word_address[15:0], load_data[47:16]
    input  logic         s_tuser,  // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], executed_pc[34:3], fetched_instruction[66:35],
    // next_pc[98:67], exit_code[130:99], zero pad above
    output logic [rvx_pkg::MDATA_W-1:0] m_tdata
);
    logic             q_valid, q_pop;
    rvx_pkg::item_t   q_item;
    rvx_pkg::result_t res;

    rvx_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    rvx_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_res(res)
    );

    assign m_tdata = rvx_pkg::MDATA_W'(res);

`ifndef SYNTHESIS
    a_halt_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status == rvx_pkg::ST_HALT |-> res.next_pc == res.executed_pc)
        else $error("ecall result moved the pc");
    a_preload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status == rvx_pkg::ST_PRELOAD
        |-> res.executed_pc == 32'd0 && res.fetched_instruction == 32'd0)
        else $error("preload result carries step fields");
    a_illegal_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status == rvx_pkg::ST_ILLEGAL
        |-> res.next_pc == res.executed_pc + 32'd4 && res.exit_code == 32'd0)
        else $error("illegal item did not skip by 4");
`endif
endmodule

// ===== tb/rvx_checker.sv =====
// Checker for the RV32I executor: watches both stream channels, predicts each result.
// Depends on rvx_pkg; instantiated beside the block by tb_rv32i_instruction_executor_core.
`timescale 1ns / 1ps
module rvx_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [47:0]                 s_tdata,  // word_address[15:0], load_data[47:16]
    input  logic                        s_tuser,  // kind
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [rvx_pkg::MDATA_W-1:0] m_tdata,  // status, executed_pc, fetched_instruction,
                                                  // next_pc, exit_code
    output int                          fail_count,
    output int                          pending,
    output int                          checked,
    output logic [31:0]                 model_pc
);
    import rvx_pkg::*;

    logic [31:0] pc_q;
    logic [31:0] regs [32];
    logic [7:0]  mem [MEM_BYTES];
    logic        halted;
    result_t     expected_q [$];
    int          nfail;
    int          nchk;

    function automatic logic [31:0] mem_rd(input logic [31:0] addr, input int nbytes);
        logic [31:0] v;
        logic [31:0] x;
        v = '0;
        for (int i = 0; i < nbytes; i++) begin
            x = addr + i;
            v[8*i +: 8] = mem[x[BYTE_W-1:0]];
        end
        return v;
    endfunction

    task automatic mem_wr(input logic [31:0] addr, input logic [31:0] v, input int nbytes);
        logic [31:0] x;
        for (int i = 0; i < nbytes; i++) begin
            x = addr + i;
            mem[x[BYTE_W-1:0]] = v[8*i +: 8];
        end
    endtask

    task automatic set_rd(input logic [4:0] rd, input logic [31:0] v);
        if (rd != 0) regs[rd] = v;
    endtask

    // Advances the predicted machine by one item and returns the result it causes.
    task automatic exec_item(input logic kind, input logic [15:0] waddr,
                             input logic [31:0] wdata, output result_t r);
        logic [31:0] ins, a, b, nxt, imm_i, imm_s, imm_b, imm_j, addr, lv;
        logic [6:0]  op, f7;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic        ok, take;
        r = '0;
        if (kind == KIND_PRELOAD) begin
            mem_wr({14'd0, waddr, 2'b00}, wdata, 4);
            r.status  = ST_PRELOAD;
            r.next_pc = pc_q;
            return;
        end
        if (halted) begin
            r.status      = ST_IGNORED;
            r.executed_pc = pc_q;
            r.next_pc     = pc_q;
            return;
        end
        ins   = mem_rd(pc_q, 4);
        op    = ins[6:0];
        rd    = ins[11:7];
        f3    = ins[14:12];
        f7    = ins[31:25];
        a     = regs[ins[19:15]];
        b     = regs[ins[24:20]];
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        nxt   = pc_q + 4;
        ok    = 1'b1;
        r.status = ST_EXEC;
        case (op)
            OP_LUI:   set_rd(rd, {ins[31:12], 12'd0});
            OP_AUIPC: set_rd(rd, pc_q + {ins[31:12], 12'd0});
            OP_JAL: begin
                set_rd(rd, pc_q + 4);
                nxt = pc_q + imm_j;
            end
            OP_JALR: begin
                nxt = (a + imm_i) & JALR_MASK;
                set_rd(rd, pc_q + 4);
            end
            OP_BRANCH: begin
                take = 1'b0;
                case (f3)
                    3'd0: take = (a == b);
                    3'd1: take = (a != b);
                    3'd4: take = ($signed(a) < $signed(b));
                    3'd5: take = !($signed(a) < $signed(b));
                    3'd6: take = (a < b);
                    3'd7: take = (a >= b);
                    default: ok = 1'b0;
                endcase
                if (ok && take) nxt = pc_q + imm_b;
            end
            OP_LOAD: begin
                addr = a + imm_i;
                case (f3)
                    3'd0: begin
                        lv = mem_rd(addr, 1);
                        set_rd(rd, {{24{lv[7]}}, lv[7:0]});
                    end
                    3'd1: begin
                        lv = mem_rd(addr, 2);
                        set_rd(rd, {{16{lv[15]}}, lv[15:0]});
                    end
                    3'd2: set_rd(rd, mem_rd(addr, 4));
                    3'd4: set_rd(rd, mem_rd(addr, 1));
                    3'd5: set_rd(rd, mem_rd(addr, 2));
                    default: ok = 1'b0;
                endcase
            end
            OP_STORE: begin
                addr = a + imm_s;
                if (f3 <= 3'd2) mem_wr(addr, b, 1 << f3);
                else ok = 1'b0;
            end
            OP_IMM: begin
                case (f3)
                    3'd0: set_rd(rd, a + imm_i);
                    3'd1: set_rd(rd, a << imm_i[4:0]);
                    3'd2: set_rd(rd, {31'd0, $signed(a) < $signed(imm_i)});
                    3'd3: set_rd(rd, {31'd0, a < imm_i});
                    3'd4: set_rd(rd, a ^ imm_i);
                    3'd5: set_rd(rd, ins[30] ? $unsigned($signed(a) >>> imm_i[4:0])
                                             : a >> imm_i[4:0]);
                    3'd6: set_rd(rd, a | imm_i);
                    default: set_rd(rd, a & imm_i);
                endcase
            end
            OP_REG: begin
                case (f3)
                    3'd0: begin
                        if (f7 == F7_ADD) set_rd(rd, a + b);
                        else if (f7 == F7_SUB) set_rd(rd, a - b);
                        else ok = 1'b0;
                    end
                    3'd1: set_rd(rd, a << b[4:0]);
                    3'd2: set_rd(rd, {31'd0, $signed(a) < $signed(b)});
                    3'd3: set_rd(rd, {31'd0, a < b});
                    3'd4: set_rd(rd, a ^ b);
                    3'd5: set_rd(rd, (f7 == 0) ? a >> b[4:0]
                                               : $unsigned($signed(a) >>> b[4:0]));
                    3'd6: set_rd(rd, a | b);
                    default: set_rd(rd, a & b);
                endcase
            end
            OP_SYSTEM: begin
                if (ins == ECALL_WORD) begin
                    r.status    = ST_HALT;
                    r.exit_code = regs[3];
                    halted      = 1'b1;
                    nxt         = pc_q;
                end else begin
                    ok = 1'b0;
                end
            end
            default: ok = 1'b0;
        endcase
        if (!ok) begin
            r.status = ST_ILLEGAL;
            nxt = pc_q + 4;
        end
        r.executed_pc         = pc_q;
        r.fetched_instruction = ins;
        r.next_pc             = nxt;
        pc_q = nxt;
    endtask

    always @(posedge aclk) begin
        result_t     r, act;
        logic [31:0] ev [5];
        logic [31:0] av [5];
        string       fname [5];
        if (!aresetn) begin
            pc_q   = '0;
            halted = 1'b0;
            foreach (regs[i]) regs[i] = '0;
            foreach (mem[i]) mem[i] = '0;
            expected_q.delete();
            nfail = 0;
            nchk  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                exec_item(s_tuser, s_tdata[15:0], s_tdata[47:16], r);
                expected_q.push_back(r);
            end
            if (m_tvalid && m_tready) begin
                act = result_t'(m_tdata[RES_W-1:0]);
                if (expected_q.size() == 0) begin
                    $display("%0t: result with nothing expected: %h", $time, act);
                    nfail++;
                end else begin
                    r = expected_q.pop_front();
                    nchk++;
                    fname = '{"status", "executed_pc", "fetched_instruction", "next_pc",
                              "exit_code"};
                    ev = '{32'(r.status), r.executed_pc, r.fetched_instruction, r.next_pc,
                           r.exit_code};
                    av = '{32'(act.status), act.executed_pc, act.fetched_instruction,
                           act.next_pc, act.exit_code};
                    for (int i = 0; i < 5; i++) begin
                        if (ev[i] !== av[i]) begin
                            $display("%0t: %s mismatch: expected %h actual %h",
                                     $time, fname[i], ev[i], av[i]);
                            nfail++;
                        end
                    end
                end
            end
        end
        fail_count <= nfail;
        checked    <= nchk;
        pending    <= expected_q.size();
        model_pc   <= pc_q;
    end

endmodule

// ===== tb/tb_rv32i_instruction_executor_core.sv =====
// Top of the RV32I executor testbench: clock, reset, program stimulus, verdict.
// Depends on rvx_pkg, rv32i_instruction_executor_core and rvx_checker.
`timescale 1ns / 1ps
module tb_rv32i_instruction_executor_core;
    import rvx_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [47:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [MDATA_W-1:0]   m_tdata;
    int                   fail_count, pending, checked;
    logic [31:0]          model_pc;
    int                   n_items, n_steps, n_preloads;
    bit                   quiet_tx;
    int unsigned          rx_cycle;
    int                   hold_left;

    rv32i_instruction_executor_core u_dut (.*);

    rvx_checker u_chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [4:0] rd,
                                          input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rd,
                                          input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, OP_REG};
    endfunction

    function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [4:0] rs2, input logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [4:0] rs2, input logic [12:0] imm);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // Instruction with random fields, mostly well-formed; some are illegal forms or noise.
    function automatic logic [31:0] rand_ins();
        logic [4:0]  rd, rs1, rs2;
        logic [31:0] w;
        logic [12:0] boff;
        logic [6:0]  f7;
        rd   = 5'($urandom_range(0, 31));
        rs1  = ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom_range(0, 31));
        rs2  = 5'($urandom_range(0, 31));
        boff = 13'($urandom_range(0, 16) * 4) - 13'd32;
        case ($urandom_range(0, 12))
            0: return {20'($urandom), rd, OP_LUI};
            1: return {20'($urandom), rd, OP_AUIPC};
            2: return enc_j(rd, 21'(boff));
            3: return enc_i(OP_JALR, rd, 3'd0, 5'd0, 12'($urandom_range(0, 255)));
            4: return enc_b(3'($urandom), rs1, rs2, boff);
            5: return enc_i(OP_LOAD, rd, 3'($urandom), rs1, 12'($urandom));
            6: return enc_s(3'($urandom), rs1, rs2, 12'($urandom));
            7, 8: return enc_i(OP_IMM, rd, 3'($urandom), rs1, 12'($urandom));
            9, 10: begin
                case ($urandom_range(0, 2))
                    0: f7 = F7_ADD;
                    1: f7 = F7_SUB;
                    default: f7 = 7'($urandom);
                endcase
                return enc_r(f7, rd, 3'($urandom), rs1, rs2);
            end
            11: begin
                w = {$urandom} | 32'h0000_1000;
                return {w[31:7], OP_SYSTEM};  // never the exact ecall word
            end
            default: begin
                w = $urandom;
                return (w == ECALL_WORD) ? 32'h0 : w;
            end
        endcase
    endfunction

    task automatic send(input logic kind, input logic [15:0] waddr, input logic [31:0] wdata);
        if (!quiet_tx && $urandom_range(0, 99) < 17) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {wdata, waddr};
        do @(posedge aclk); while (!s_tready);
        n_items++;
        if (kind == KIND_PRELOAD) n_preloads++;
        else n_steps++;
    endtask

    task automatic step();
        send(KIND_STEP, 16'($urandom), $urandom);
    endtask

    // Stops offering items and waits until every result has been taken.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Puts a jump to byte address base_b at the current pc, which may sit mid-word.
    task automatic plant_jump(input logic [31:0] base_b);
        logic [31:0] pcw, jw;
        logic [15:0] w;
        pcw = model_pc & (MEM_BYTES - 1);
        jw  = enc_j(5'($urandom_range(0, 1)), 21'(base_b - pcw));
        w   = pcw[BYTE_W-1:2];
        if (!pcw[1]) begin
            send(KIND_PRELOAD, w, jw);
        end else begin
            send(KIND_PRELOAD, w, {jw[15:0], 16'h0});
            send(KIND_PRELOAD, w + 16'd1, {16'h0, jw[31:16]});
        end
    endtask

    // Receiver: random stalls, one quiet stretch and one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rx_cycle  <= 0;
            hold_left <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle == 70000) hold_left <= 400;
            else if (hold_left > 0) hold_left <= hold_left - 1;
            if (hold_left > 0 || rx_cycle == 70000) m_tready <= 1'b0;
            else if (rx_cycle > 74000 && rx_cycle < 76000) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 99) >= 17);
        end
    end

    initial begin
        logic [31:0] prog [$];
        int          base, n;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_STEP;
        aresetn    = 1'b0;
        quiet_tx   = 1'b0;
        n_items    = 0;
        n_steps    = 0;
        n_preloads = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed program at address 0: sign and shift corners, illegal forms,
        // accesses that wrap past the end of memory, and a jump to a misaligned pc.
        send(KIND_PRELOAD, 16'hFFFF, 32'hFFFF_FFFF);
        prog = '{enc_i(OP_IMM, 5'd1, 3'd0, 5'd0, 12'hFFF),
                 {20'h80000, 5'd2, OP_LUI},
                 enc_i(OP_IMM, 5'd4, 3'd5, 5'd2, 12'h404),
                 enc_r(7'h01, 5'd5, 3'd5, 5'd2, 5'd1),
                 enc_r(F7_SUB, 5'd6, 3'd0, 5'd0, 5'd1),
                 enc_r(7'h01, 5'd7, 3'd0, 5'd1, 5'd1),
                 enc_s(3'd2, 5'd0, 5'd2, 12'hFFF),
                 enc_i(OP_LOAD, 5'd7, 3'd2, 5'd0, 12'hFFF),
                 enc_i(OP_LOAD, 5'd8, 3'd1, 5'd0, 12'hFFF),
                 enc_b(3'd2, 5'd0, 5'd0, 13'd8),
                 enc_i(OP_LOAD, 5'd9, 3'd3, 5'd0, 12'd0),
                 enc_s(3'd5, 5'd0, 5'd1, 12'd0),
                 32'h0010_0073,
                 {20'hFFFFF, 5'd3, OP_AUIPC},
                 enc_i(OP_JALR, 5'd10, 3'd0, 5'd1, 12'd3)};
        foreach (prog[i]) send(KIND_PRELOAD, 16'(i), prog[i]);
        repeat (prog.size() + 2) step();

        // Random programs: each round jumps from wherever the pc is into fresh code.
        while (n_items < 1850) begin
            quiet_tx = (n_items > 1000 && n_items < 1200);
            wait_idle();
            base = $urandom_range(0, 4000);
            n    = $urandom_range(4, 20);
            plant_jump(base * 4);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send(KIND_PRELOAD, 16'($urandom), $urandom);
                send(KIND_PRELOAD, 16'(base + i), rand_ins());
            end
            repeat (n + $urandom_range(1, 4)) step();
        end

        // Halt: load an exit code into x3, ecall, then items after the halt.
        wait_idle();
        base = $urandom_range(0, 4000);
        plant_jump(base * 4);
        send(KIND_PRELOAD, 16'(base), {20'($urandom), 5'd3, OP_LUI});
        send(KIND_PRELOAD, 16'(base + 1), enc_i(OP_IMM, 5'd3, 3'd0, 5'd3, 12'($urandom)));
        send(KIND_PRELOAD, 16'(base + 2), ECALL_WORD);
        repeat (6) step();
        send(KIND_PRELOAD, 16'($urandom), $urandom);
        repeat (2) step();

        wait_idle();
        repeat (20) @(posedge aclk);
        $display("Ran %0d items (%0d steps, %0d preloads), %0d results checked,",
                 n_items, n_steps, n_preloads, checked);
        $display("covering random RV32I programs, illegal forms, wrapped accesses and halt.");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("FAILURE");
        $finish;
    end

endmodule
